// ===== rtl/core/ocd_pkg.sv =====
package ocd_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int COUNT_W    = 32;
    localparam int YAW_W      = 16;
    localparam int SCALE_W    = 32;
    localparam int OUT_W      = 48;

    // config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SCALE   = 2'd1;

    // quarter-wave sine polynomial, Q16
    localparam int ONE_Q16 = 65536;
    localparam int POLY_A  = 102944;
    localparam int POLY_B  = 42334;
    localparam int POLY_C  = 4926;

    localparam int U_W     = 17;
    localparam int Q15_W   = 15;
    localparam int TRIG_W  = 16;

    localparam int DELTA_W = 35;
    localparam int ROT_W   = 51;
    localparam int MAG_W   = 52;
    localparam int INC_W   = 53;

    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef logic signed [MUL_A_W-1:0] t_mul_a;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [MUL_P_W-1:0] t_mul_p;
    typedef logic signed [INC_W-1:0]   t_inc;

endpackage

// ===== rtl/core/ocd_mul.sv =====
module ocd_mul
    import ocd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_mul_a i_a,
    input  t_mul_b i_b,
    output t_mul_p o_p
);

    t_mul_p r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/ocd_sat_add.sv =====
module ocd_sat_add
    import ocd_pkg::*;
#(
    parameter int ACC_WIDTH = 48
) (
    input  logic signed [ACC_WIDTH-1:0] i_acc,
    input  t_inc                        i_inc,
    output logic signed [ACC_WIDTH-1:0] o_sum
);

    localparam int SW = ((ACC_WIDTH > INC_W) ? ACC_WIDTH : INC_W) + 1;

    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;

    always_comb begin
        sum = SW'(i_acc) + SW'(i_inc);
        hi  = SW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
        lo  = ~hi;
        if (sum > hi) begin
            o_sum = ACC_WIDTH'(hi);
        end else if (sum < lo) begin
            o_sum = ACC_WIDTH'(lo);
        end else begin
            o_sum = ACC_WIDTH'(sum);
        end
    end

endmodule

// ===== rtl/core/omni_chassis_odometry.sv =====
// channel | direction | handshake                  | payload
// in      | request   | i_in_valid / o_in_stall    | four wheel totals, relative and imu yaw
// out     | result    | o_out_valid / i_out_stall  | six 48-bit accumulators
// cfg     | write     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An accepted request runs 36 products on the one shared multiplier, each issued
// and then written back before the next one issues.
// Synchronous active-low reset clears counts, accumulators and scale registers.
// The next request is taken while a result still waits under i_out_stall;
// its result is held back until the output register is free.
module omni_chassis_odometry
    import ocd_pkg::*;
#(
    parameter int ACC_WIDTH  = 48,
    parameter int ANGLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [COUNT_W-1:0]   i_wheel0_count,
    input  logic signed [COUNT_W-1:0]   i_wheel1_count,
    input  logic signed [COUNT_W-1:0]   i_wheel2_count,
    input  logic signed [COUNT_W-1:0]   i_wheel3_count,
    input  logic signed [YAW_W-1:0]     i_relative_yaw,
    input  logic signed [YAW_W-1:0]     i_imu_yaw,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [OUT_W-1:0]     o_gimbal_dist_x,
    output logic signed [OUT_W-1:0]     o_gimbal_dist_y,
    output logic signed [OUT_W-1:0]     o_gimbal_heading,
    output logic signed [OUT_W-1:0]     o_field_pos_x,
    output logic signed [OUT_W-1:0]     o_field_pos_y,
    output logic signed [OUT_W-1:0]     o_field_heading,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [SCALE_W-1:0]          i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_SINE  = 3'd2;
    localparam logic [2:0] ST_ROT   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int NUM_ACC = 6;

    logic [2:0]                  r_state;
    logic [2:0]                  r_idx;
    logic [1:0]                  r_sub;
    logic                        r_wb;

    logic [SCALE_W-1:0]          r_linear;
    logic [SCALE_W-1:0]          r_turn;

    logic [COUNT_W-1:0]          r_last [NUM_WHEELS];
    logic signed [COUNT_W-1:0]   r_d [NUM_WHEELS];
    logic signed [DELTA_W-1:0]   r_dx;
    logic signed [DELTA_W-1:0]   r_dy;
    logic signed [DELTA_W-1:0]   r_dw;
    logic [ANGLE_BITS-1:0]       r_phase_g;
    logic [ANGLE_BITS-1:0]       r_phase_f;

    logic [U_W-1:0]              r_u2;
    logic [U_W-1:0]              r_t;
    logic [Q15_W-1:0]            r_qs [4];
    logic signed [ROT_W-1:0]     r_part;
    logic signed [ROT_W-1:0]     r_rot [4];

    logic signed [ACC_WIDTH-1:0] r_acc [NUM_ACC];
    logic                        r_out_valid;
    logic signed [OUT_W-1:0]     r_out [NUM_ACC];

    logic [COUNT_W-1:0]          w_now [NUM_WHEELS];
    logic signed [31:0]          rel32;
    logic signed [31:0]          imu32;
    logic [ANGLE_BITS-1:0]       rel_a;
    logic [ANGLE_BITS-1:0]       imu_a;
    logic                        in_acc;
    logic                        out_free;

    logic [ANGLE_BITS-1:0]       ph;
    logic [47:0]                 fw;
    logic [U_W-1:0]              u;
    logic [U_W-1:0]              x;
    logic [Q15_W-1:0]            qa;
    logic [Q15_W-1:0]            qb;
    logic signed [TRIG_W-1:0]    sv;
    logic signed [TRIG_W-1:0]    cv;

    logic                        is_turn;
    logic [1:0]                  rsel;
    logic signed [ROT_W-1:0]     v;
    logic                        neg;
    logic [ROT_W-2:0]            m;
    logic [SCALE_W-1:0]          k;
    logic [59:0]                 tsum;
    logic [MAG_W-1:0]            mag;
    t_inc                        inc;
    logic [17:0]                 qv;
    logic [16:0]                 q17;

    t_mul_a                      mul_a;
    t_mul_b                      mul_b;
    t_mul_p                      p;
    logic                        mul_en;
    logic signed [ACC_WIDTH-1:0] acc_new;

    assign w_now[0] = i_wheel0_count;
    assign w_now[1] = i_wheel1_count;
    assign w_now[2] = i_wheel2_count;
    assign w_now[3] = i_wheel3_count;

    assign rel32 = 32'(i_relative_yaw);
    assign imu32 = 32'(i_imu_yaw);
    assign rel_a = rel32[ANGLE_BITS-1:0];
    assign imu_a = imu32[ANGLE_BITS-1:0];

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign mul_en      = !r_wb;

    // angle -> quadrant and Q0.16 fraction
    always_comb begin
        if (r_state == ST_SINE) begin
            ph = r_idx[1] ? r_phase_f : r_phase_g;
        end else begin
            ph = r_idx[0] ? r_phase_f : r_phase_g;
        end
        fw = 48'(ph[ANGLE_BITS-3:0]) << 24;
        u  = U_W'(fw >> (ANGLE_BITS + 6));
        x  = r_idx[0] ? (U_W'(ONE_Q16) - u) : u;
    end

    // quadrant symmetry for the frame in rotation
    always_comb begin
        qa = r_qs[{r_idx[0], 1'b0}];
        qb = r_qs[{r_idx[0], 1'b1}];
        case (ph[ANGLE_BITS-1 -: 2])
            2'd0: begin
                sv = TRIG_W'(qa);
                cv = TRIG_W'(qb);
            end
            2'd1: begin
                sv = TRIG_W'(qb);
                cv = -TRIG_W'(qa);
            end
            2'd2: begin
                sv = -TRIG_W'(qa);
                cv = -TRIG_W'(qb);
            end
            default: begin
                sv = -TRIG_W'(qb);
                cv = TRIG_W'(qa);
            end
        endcase
    end

    // scaling: items run gimbal x, y, heading, then field x, y, heading
    always_comb begin
        is_turn = (r_idx == 3'd2) || (r_idx == 3'd5);
        rsel    = (r_idx < 3'd3) ? r_idx[1:0] : 2'(r_idx - 3'd1);
        v       = is_turn ? ROT_W'(r_dw) : r_rot[rsel];
        neg     = v[ROT_W-1];
        m       = neg ? (ROT_W-1)'(-v) : (ROT_W-1)'(v);
        k       = is_turn ? r_turn : r_linear;
        if (is_turn) begin
            tsum = 60'({p[57:0], 1'b0}) + 60'(r_part);
            mag  = tsum[MAG_W-1:0];
        end else begin
            tsum = 60'(p[57:0]) + 60'(r_part);
            mag  = tsum[MAG_W+5:6];
        end
        inc = neg ? -INC_W'(mag) : INC_W'(mag);
        qv  = 18'(p[32:16]) + 18'd1;
        q17 = qv[17:1];
    end

    // multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SINE: begin
                case (r_sub)
                    2'd0: begin
                        mul_a = MUL_A_W'(x);
                        mul_b = MUL_B_W'(x);
                    end
                    2'd1: begin
                        mul_a = MUL_A_W'(POLY_C);
                        mul_b = MUL_B_W'(r_u2);
                    end
                    2'd2: begin
                        mul_a = MUL_A_W'(r_t);
                        mul_b = MUL_B_W'(r_u2);
                    end
                    default: begin
                        mul_a = MUL_A_W'(r_t);
                        mul_b = MUL_B_W'(x);
                    end
                endcase
            end
            ST_ROT: begin
                case (r_sub)
                    2'd0: begin
                        mul_a = r_dx;
                        mul_b = MUL_B_W'(cv);
                    end
                    2'd1: begin
                        mul_a = r_dy;
                        mul_b = MUL_B_W'(sv);
                    end
                    2'd2: begin
                        mul_a = r_dx;
                        mul_b = MUL_B_W'(sv);
                    end
                    default: begin
                        mul_a = r_dy;
                        mul_b = MUL_B_W'(cv);
                    end
                endcase
            end
            ST_SCALE: begin
                mul_b = MUL_B_W'(k);
                if (r_sub == 2'd0) begin
                    mul_a = is_turn ? MUL_A_W'(m[16:0]) : MUL_A_W'(m[24:0]);
                end else begin
                    mul_a = is_turn ? MUL_A_W'(m[33:17]) : MUL_A_W'(m[49:25]);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ocd_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (p)
    );

    ocd_sat_add #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_sat (
        .i_acc (r_acc[r_idx]),
        .i_inc (inc),
        .o_sum (acc_new)
    );

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear <= '0;
            r_turn   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LINEAR_SCALE: r_linear <= i_cfg_data;
                REG_TURN_SCALE:   r_turn   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_sub       <= '0;
            r_wb        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_last[i] <= '0;
            end
            for (int i = 0; i < NUM_ACC; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        for (int i = 0; i < NUM_WHEELS; i++) begin
                            r_d[i]    <= signed'(w_now[i] - r_last[i]);
                            r_last[i] <= w_now[i];
                        end
                        r_phase_g <= -rel_a;
                        r_phase_f <= imu_a - rel_a;
                        r_idx     <= '0;
                        r_sub     <= '0;
                        r_wb      <= 1'b0;
                        r_state   <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_dx    <= -DELTA_W'(r_d[0]) + DELTA_W'(r_d[1])
                               + DELTA_W'(r_d[2]) - DELTA_W'(r_d[3]);
                    r_dy    <= -DELTA_W'(r_d[0]) - DELTA_W'(r_d[1])
                               + DELTA_W'(r_d[2]) + DELTA_W'(r_d[3]);
                    r_dw    <= -(DELTA_W'(r_d[0]) + DELTA_W'(r_d[1])
                               + DELTA_W'(r_d[2]) + DELTA_W'(r_d[3]));
                    r_state <= ST_SINE;
                end
                ST_SINE: begin
                    r_wb <= !r_wb;
                    if (r_wb) begin
                        case (r_sub)
                            2'd0: r_u2 <= p[32:16];
                            2'd1: r_t  <= U_W'(POLY_B) - p[32:16];
                            2'd2: r_t  <= U_W'(POLY_A) - p[32:16];
                            default: begin
                                r_qs[r_idx[1:0]] <= (q17 > 17'd32767) ? {Q15_W{1'b1}}
                                                                       : q17[Q15_W-1:0];
                            end
                        endcase
                        r_sub <= r_sub + 2'd1;
                        if (r_sub == 2'd3) begin
                            if (r_idx == 3'd3) begin
                                r_idx   <= '0;
                                r_state <= ST_ROT;
                            end else begin
                                r_idx <= r_idx + 3'd1;
                            end
                        end
                    end
                end
                ST_ROT: begin
                    r_wb <= !r_wb;
                    if (r_wb) begin
                        case (r_sub)
                            2'd0: r_part <= p[ROT_W-1:0];
                            2'd1: r_rot[{r_idx[0], 1'b0}] <= r_part - p[ROT_W-1:0];
                            2'd2: r_part <= p[ROT_W-1:0];
                            default: r_rot[{r_idx[0], 1'b1}] <= r_part + p[ROT_W-1:0];
                        endcase
                        r_sub <= r_sub + 2'd1;
                        if (r_sub == 2'd3) begin
                            if (r_idx == 3'd1) begin
                                r_idx   <= '0;
                                r_state <= ST_SCALE;
                            end else begin
                                r_idx <= r_idx + 3'd1;
                            end
                        end
                    end
                end
                ST_SCALE: begin
                    r_wb <= !r_wb;
                    if (r_wb) begin
                        if (r_sub == 2'd0) begin
                            r_part <= is_turn ? ROT_W'(p[49:16]) : ROT_W'(p[57:25]);
                            r_sub  <= 2'd1;
                        end else begin
                            r_acc[r_idx] <= acc_new;
                            r_sub        <= 2'd0;
                            if (r_idx == 3'd5) begin
                                r_idx   <= '0;
                                r_state <= ST_DONE;
                            end else begin
                                r_idx <= r_idx + 3'd1;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        for (int i = 0; i < NUM_ACC; i++) begin
                            r_out[i] <= OUT_W'(r_acc[i]);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_gimbal_dist_x  = r_out[0];
    assign o_gimbal_dist_y  = r_out[1];
    assign o_gimbal_heading = r_out[2];
    assign o_field_pos_x    = r_out[3];
    assign o_field_pos_y    = r_out[4];
    assign o_field_heading  = r_out[5];

endmodule

// ===== dv/omni_chassis_odometry_tb.sv =====
`timescale 1ns / 100ps

module omni_chassis_odometry_tb;
    import ocd_pkg::*;

    localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam int     SETTLE  = 80;

    typedef struct packed {
        logic signed [OUT_W-1:0] gim_x;
        logic signed [OUT_W-1:0] gim_y;
        logic signed [OUT_W-1:0] gim_head;
        logic signed [OUT_W-1:0] fld_x;
        logic signed [OUT_W-1:0] fld_y;
        logic signed [OUT_W-1:0] fld_head;
    } pose_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [COUNT_W-1:0] i_wheel0_count = '0;
    logic signed [COUNT_W-1:0] i_wheel1_count = '0;
    logic signed [COUNT_W-1:0] i_wheel2_count = '0;
    logic signed [COUNT_W-1:0] i_wheel3_count = '0;
    logic signed [YAW_W-1:0]   i_relative_yaw = '0;
    logic signed [YAW_W-1:0]   i_imu_yaw = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [OUT_W-1:0]   o_gimbal_dist_x, o_gimbal_dist_y, o_gimbal_heading;
    logic signed [OUT_W-1:0]   o_field_pos_x, o_field_pos_y, o_field_heading;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [SCALE_W-1:0]        i_cfg_data = '0;

    omni_chassis_odometry uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [SCALE_W-1:0] lin_scale, turn_scale;
    logic [31:0]        last_counts[4];
    longint             gim_acc[3], fld_acc[3];

    pose_t  pose_q[$];
    int     errors = 0;
    int     ticks_sent = 0;
    int     poses_seen = 0;
    int     tx_idle = 0, rx_idle = 0;
    int     rx_hold = 0;
    logic [31:0] cur[4];

    function automatic longint quarter_wave(longint u);
        longint u2, t;
        u2 = (u * u) >>> 16;
        t  = (longint'(POLY_C) * u2) >>> 16;
        t  = POLY_B - t;
        t  = (t * u2) >>> 16;
        t  = POLY_A - t;
        t  = (t * u) >>> 16;
        t  = (t + 1) >>> 1;
        if (t > 32767) t = 32767;
        return t;
    endfunction

    function automatic longint scale_by(longint v, logic [31:0] k);
        longint unsigned m, hi, lo, r;
        m  = (v < 0) ? longint'(-v) : longint'(v);
        hi = (m >> 25) * {32'd0, k};
        lo = (m & 64'h1FF_FFFF) * {32'd0, k};
        r  = (hi + (lo >> 25)) >> 6;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint sat_acc(longint acc, longint d);
        if (d > 0 && acc > ACC_MAX - d) return ACC_MAX;
        if (d < 0 && acc < ACC_MIN - d) return ACC_MIN;
        return acc + d;
    endfunction

    task automatic rotate_into(inout longint acc[3], input logic [15:0] ph,
                               input longint dx, input longint dy, input longint dturn);
        longint a, b, s, c, u;
        u = longint'({ph[13:0], 2'b00});
        a = quarter_wave(u);
        b = quarter_wave(ONE_Q16 - u);
        case (ph[15:14])
            2'd0: begin s = a;  c = b;  end
            2'd1: begin s = b;  c = -a; end
            2'd2: begin s = -a; c = -b; end
            default: begin s = -b; c = a; end
        endcase
        acc[0] = sat_acc(acc[0], scale_by(c * dx - s * dy, lin_scale));
        acc[1] = sat_acc(acc[1], scale_by(s * dx + c * dy, lin_scale));
        acc[2] = sat_acc(acc[2], dturn);
    endtask

    task automatic advance_odometry(input logic [31:0] w[4], input logic [15:0] rel,
                                    input logic [15:0] imu);
        longint d[4], dx, dy, dw, dturn;
        pose_t  p;
        for (int i = 0; i < 4; i++) begin
            d[i] = longint'(int'(w[i] - last_counts[i]));
            last_counts[i] = w[i];
        end
        dx = -d[0] + d[1] + d[2] - d[3];
        dy = -d[0] - d[1] + d[2] + d[3];
        dw = -(d[0] + d[1] + d[2] + d[3]);
        dturn = scale_by(dw * 32768, turn_scale);
        rotate_into(gim_acc, 16'(-rel), dx, dy, dturn);
        rotate_into(fld_acc, 16'(imu - rel), dx, dy, dturn);
        p.gim_x = gim_acc[0][47:0]; p.gim_y = gim_acc[1][47:0];
        p.gim_head = gim_acc[2][47:0];
        p.fld_x = fld_acc[0][47:0]; p.fld_y = fld_acc[1][47:0];
        p.fld_head = fld_acc[2][47:0];
        pose_q.push_back(p);
    endtask

    // one request; valid stays high afterwards until the next call or drop_valid
    task automatic send_tick(input logic [31:0] w[4], input logic [15:0] rel,
                             input logic [15:0] imu);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_wheel0_count = w[0]; i_wheel1_count = w[1];
        i_wheel2_count = w[2]; i_wheel3_count = w[3];
        i_relative_yaw = rel;  i_imu_yaw = imu;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        advance_odometry(w, rel, imu);
        ticks_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        drop_valid();
        wait (pose_q.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_LINEAR_SCALE) lin_scale = val;
        else if (idx == REG_TURN_SCALE) turn_scale = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_scales(input logic [31:0] lin, input logic [31:0] turn);
        wait_idle();
        write_reg(REG_LINEAR_SCALE, lin);
        write_reg(REG_TURN_SCALE, turn);
    endtask

    task automatic tick_abs(input logic [31:0] a, b, c, d, input logic [15:0] rel, imu);
        logic [31:0] w[4];
        w = '{a, b, c, d};
        cur = w;
        send_tick(w, rel, imu);
    endtask

    // motion of up to +/- span on top of the last totals, as a real chassis produces
    task automatic tick_motion(input int span);
        logic [31:0] w[4];
        for (int i = 0; i < 4; i++) w[i] = cur[i] + 32'($urandom_range(2 * span) - span);
        cur = w;
        send_tick(w, 16'($urandom), 16'($urandom));
    endtask

    task automatic tick_noise();
        tick_abs($urandom, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_zero_scales();
        // registers still at reset: only totals move, outputs stay zero
        tick_abs(32'd1000, -32'sd5, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000);
        tick_abs(32'd0, 32'd0, 32'd0, 32'd0, 16'h0000, 16'h0000);
    endtask

    task automatic test_directed();
        set_scales(32'h0001_0000, 32'h0000_8000);
        // first-tick style deltas, every quadrant of the gimbal angle, three of the field angle
        tick_abs(32'd100, 32'd0, 32'd0, 32'd0, 16'h0000, 16'h0000);
        tick_abs(32'd100, 32'd50, 32'd0, 32'd0, 16'h4000, 16'h0000);
        tick_abs(32'd100, 32'd50, 32'd25, 32'd0, 16'h8000, 16'h4000);
        tick_abs(32'd100, 32'd50, 32'd25, 32'd10, 16'hC000, 16'h8000);
        tick_abs(32'd90, 32'd40, 32'd15, 32'd0, 16'h7FFF, 16'hFFFF);
        tick_abs(32'd80, 32'd30, 32'd5, -32'sd10, 16'h8000, 16'h7FFF);
        tick_abs(32'd80, 32'd30, 32'd5, -32'sd10, 16'h1234, 16'h1234);
        // encoder wrap in both directions
        tick_abs(32'h7FFF_FFF0, 32'h8000_0010, 32'h7FFF_FFFF, 32'h8000_0000,
                 16'h0001, 16'hFFFF);
        tick_abs(32'h8000_0010, 32'h7FFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF,
                 16'hFFFF, 16'h0001);
        tick_abs(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 16'h2000, 16'hE000);
    endtask

    task automatic test_saturation();
        set_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int n = 0; n < 6; n++) begin
            tick_abs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     16'h0000, 16'h0000);
            tick_abs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     16'h0000, 16'h0000);
        end
        for (int n = 0; n < 6; n++) begin
            tick_abs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     16'h8000, 16'h4000);
            tick_abs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     16'h8000, 16'h4000);
        end
    endtask

    task automatic test_unknown_index();
        wait_idle();
        write_reg(2'd2, 32'hDEAD_BEEF);
        write_reg(2'd3, 32'h1234_5678);
        tick_motion(1000);
        tick_motion(1000);
    endtask

    task automatic test_random_phase(input int n);
        logic [31:0] lin, turn;
        case ($urandom_range(2))
            0: begin lin = $urandom_range(32'hFFFF); turn = $urandom_range(32'hFFFF); end
            1: begin lin = $urandom; turn = $urandom; end
            default: begin lin = 32'h1; turn = 32'h0; end
        endcase
        set_scales(lin, turn);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: tick_noise();
                1: tick_motion(32'h0FFF_FFFF);
                default: tick_motion(5000);
            endcase
        end
    endtask

    task automatic test_backpressure();
        set_scales(32'h0002_0000, 32'h0000_4000);
        @(negedge i_clk);
        rx_hold = 400;
        for (int i = 0; i < 6; i++) tick_motion(3000);
        // wait for every pose before the next request
        drop_valid();
        wait (pose_q.size() == 0);
        for (int i = 0; i < 3; i++) tick_motion(3000);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    always @(posedge i_clk) begin
        pose_t e, a;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            a = '{o_gimbal_dist_x, o_gimbal_dist_y, o_gimbal_heading,
                  o_field_pos_x, o_field_pos_y, o_field_heading};
            poses_seen++;
            if (pose_q.size() == 0) begin
                $display("%0t: pose with none expected %h", $time, a);
                errors++;
            end else begin
                e = pose_q.pop_front();
                if (e.gim_x !== a.gim_x)
                    $display("%0t: gimbal_dist_x exp %0d got %0d", $time, e.gim_x, a.gim_x);
                if (e.gim_y !== a.gim_y)
                    $display("%0t: gimbal_dist_y exp %0d got %0d", $time, e.gim_y, a.gim_y);
                if (e.gim_head !== a.gim_head)
                    $display("%0t: gimbal_heading exp %0d got %0d", $time, e.gim_head,
                             a.gim_head);
                if (e.fld_x !== a.fld_x)
                    $display("%0t: field_pos_x exp %0d got %0d", $time, e.fld_x, a.fld_x);
                if (e.fld_y !== a.fld_y)
                    $display("%0t: field_pos_y exp %0d got %0d", $time, e.fld_y, a.fld_y);
                if (e.fld_head !== a.fld_head)
                    $display("%0t: field_heading exp %0d got %0d", $time, e.fld_head,
                             a.fld_head);
                if (e !== a) errors++;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        lin_scale = '0; turn_scale = '0;
        for (int i = 0; i < 4; i++) begin last_counts[i] = '0; cur[i] = '0; end
        for (int i = 0; i < 3; i++) begin gim_acc[i] = 0; fld_acc[i] = 0; end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_scales();
        test_directed();
        test_saturation();
        test_unknown_index();
        tx_idle = 6; rx_idle = 70;
        for (int p = 0; p < 3; p++) test_random_phase(220);
        tx_idle = 70; rx_idle = 6;
        for (int p = 0; p < 3; p++) test_random_phase(220);
        test_backpressure();
        tx_idle = 0; rx_idle = 0;
        for (int p = 0; p < 3; p++) test_random_phase(220);
        set_scales(32'h0, 32'hFFFF_FFFF);
        for (int i = 0; i < 20; i++) tick_motion(100000);
        wait_idle();

        $display("Odometry run: %0d ticks, %0d poses checked, scales from zero to full range,",
                 ticks_sent, poses_seen);
        $display("encoder and angle wrap, saturation, output hold-off and sender pauses.");
        if (errors == 0 && pose_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
